// File: hdl/mbpl_pkg.sv
// Shared types and constants for the media box path locator.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbpl_pkg;

  // Deepest search path supported by the design.
  localparam int unsigned PATH_DEPTH = 3;
  // Number of type registers in the configuration space.
  localparam int unsigned TYPE_REGS = 3;
  // Largest effective path length: the smaller of the two limits above.
  localparam logic [1:0] LEN_MAX =
    2'((PATH_DEPTH < TYPE_REGS) ? PATH_DEPTH : TYPE_REGS);

  // Box header size in bytes.
  localparam logic [31:0] HDR_BYTES = 32'd8;
  localparam logic [2:0]  HDR_LAST  = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PATH_LENGTH = 2'd0;
  localparam logic [1:0] CFG_TYPE_FIRST  = 2'd1;
  localparam logic [1:0] CFG_TYPE_SECOND = 2'd2;
  localparam logic [1:0] CFG_TYPE_THIRD  = 2'd3;

  // Configuration reset values: a three-level path moov / udta / stem.
  localparam logic [1:0]  RST_PATH_LENGTH = 2'd3;
  localparam logic [31:0] RST_TYPE_FIRST  = 32'h6D6F6F76;
  localparam logic [31:0] RST_TYPE_SECOND = 32'h75647461;
  localparam logic [31:0] RST_TYPE_THIRD  = 32'h7374656D;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;

  // Search phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_SKIP    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_size;
    logic        payload_last;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/media_box_path_locator_unit.sv
// Top level of the media box path locator: input register, search core and
// result register. Depends on mbpl_pkg, mbpl_in_reg, mbpl_core, mbpl_out_reg.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  data_byte, end_of_file
//   out_     output     out_valid/out_stall  result_kind, payload_byte,
//                                            payload_size, payload_last
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while out_stall does not back up the path; a
// result is registered in the result register after its byte has passed the
// input register and the search core.
// The search core updates its state once per byte, as the byte moves on
// from the input register.
// Reset is synchronous and active low; it restores the default path and
// starts a fresh search. The configuration port is always ready.
// While out_stall holds a result, one more byte is held in the input
// register, after which in_stall rises.
`default_nettype none

module media_box_path_locator_unit
  import mbpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [31:0]      out_payload_size,
  output logic             out_payload_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  in_item_t in_item, item;
  logic     item_vld, item_go, out_free, res_vld;
  result_t  res, out_res;

  assign in_item.data_byte   = in_data_byte;
  assign in_item.end_of_file = in_end_of_file;

  // A byte moves into the core when the result register can take its result.
  assign item_go   = item_vld && out_free;
  assign cfg_ready = 1'b1;

  mbpl_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .item_go  (item_go),
    .item_vld (item_vld),
    .item     (item)
  );

  mbpl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_go   (item_go),
    .item      (item),
    .res_vld   (res_vld),
    .res       (res)
  );

  mbpl_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_go   (item_go),
    .res_vld   (res_vld),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind  = out_res.result_kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_payload_size = out_res.payload_size;
  assign out_payload_last = out_res.payload_last;

endmodule

`default_nettype wire

// File: hdl/mbpl_in_reg.sv
// Input register stage of the media box path locator.
// Depends on mbpl_pkg for the input request type.
`default_nettype none

module mbpl_in_reg
  import mbpl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     item_go,
  output logic          item_vld,
  output in_item_t      item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     accept;

  // The register takes a new request when empty or when its request moves on.
  assign in_stall = vld_r && !item_go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (item_go) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

// File: hdl/mbpl_core.sv
// Box path search core: configuration registers, search state and the
// per-byte update. Depends on mbpl_pkg for types and constants.
`default_nettype none

module mbpl_core
  import mbpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        item_go,
  input  wire in_item_t    item,
  output logic             res_vld,
  output result_t          res
);

  // Configuration registers.
  logic [1:0]  path_len_r;
  logic [31:0] type_first_r, type_second_r, type_third_r;

  // Search state.
  phase_t      phase_r, phase_nxt;
  logic [55:0] hdr_shift_r, hdr_shift_nxt;
  logic [2:0]  hdr_count_r, hdr_count_nxt;
  logic [31:0] skip_left_r, skip_left_nxt;
  logic [31:0] level_left_r, level_left_nxt;
  logic [1:0]  depth_r, depth_nxt;
  logic [31:0] pl_left_r, pl_left_nxt;
  logic [31:0] pl_total_r, pl_total_nxt;

  // Working signals of the byte update.
  logic [63:0] hdr_word;
  logic [31:0] box_len, box_type, body, lvl_dec, lvl_now, want_type;
  logic [1:0]  eff_len;
  logic        bounded, type_hit, last_level, fin;
  logic [1:0]  fin_kind;

  // Configuration writes; the port is always ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_len_r    <= RST_PATH_LENGTH;
      type_first_r  <= RST_TYPE_FIRST;
      type_second_r <= RST_TYPE_SECOND;
      type_third_r  <= RST_TYPE_THIRD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATH_LENGTH: path_len_r    <= cfg_data[1:0];
        CFG_TYPE_FIRST:  type_first_r  <= cfg_data;
        CFG_TYPE_SECOND: type_second_r <= cfg_data;
        CFG_TYPE_THIRD:  type_third_r  <= cfg_data;
        default:         path_len_r    <= path_len_r;
      endcase
    end
  end

  // Path length clamped to the supported range, zero acting as one.
  always_comb begin
    if (path_len_r == 2'd0) begin
      eff_len = 2'd1;
    end else if (path_len_r > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = path_len_r;
    end
  end

  // Type wanted at the current depth.
  always_comb begin
    case (depth_r)
      2'd0:    want_type = type_first_r;
      2'd1:    want_type = type_second_r;
      2'd2:    want_type = type_third_r;
      default: want_type = type_first_r;
    endcase
  end

  assign hdr_word   = {hdr_shift_r, item.data_byte};
  assign box_len    = hdr_word[63:32];
  assign box_type   = hdr_word[31:0];
  assign body       = box_len - HDR_BYTES;
  assign bounded    = (depth_r != 2'd0);
  assign lvl_dec    = level_left_r - 32'd1;
  assign lvl_now    = bounded ? lvl_dec : level_left_r;
  assign type_hit   = (depth_r < eff_len) && (box_type == want_type);
  assign last_level = ({1'b0, depth_r} + 3'd1) >= {1'b0, eff_len};

  // Per-byte update of the search state and the result it gives.
  always_comb begin
    phase_nxt      = phase_r;
    hdr_shift_nxt  = hdr_shift_r;
    hdr_count_nxt  = hdr_count_r;
    skip_left_nxt  = skip_left_r;
    level_left_nxt = level_left_r;
    depth_nxt      = depth_r;
    pl_left_nxt    = pl_left_r;
    pl_total_nxt   = pl_total_r;
    res_vld        = 1'b0;
    res            = '0;
    fin            = 1'b0;
    fin_kind       = KIND_NOT_FOUND;

    case (phase_r)
      PH_HEADER: begin
        level_left_nxt = lvl_now;
        hdr_shift_nxt  = hdr_word[55:0];
        if (hdr_count_r != HDR_LAST) begin
          hdr_count_nxt = hdr_count_r + 3'd1;
          // The parent ran out inside this header.
          if (bounded && (lvl_dec == 32'd0)) begin
            fin      = 1'b1;
            fin_kind = KIND_MALFORMED;
          end
        end else begin
          hdr_count_nxt = 3'd0;
          if (box_len < HDR_BYTES) begin
            fin      = 1'b1;
            fin_kind = KIND_MALFORMED;
          end else if (bounded && (body > lvl_now)) begin
            // Child box larger than what remains of its parent.
            fin      = 1'b1;
            fin_kind = KIND_MALFORMED;
          end else if (type_hit) begin
            if (last_level) begin
              if (body == 32'd0) begin
                fin = 1'b1;
              end else begin
                pl_left_nxt  = body;
                pl_total_nxt = body;
                phase_nxt    = PH_PAYLOAD;
              end
            end else begin
              depth_nxt      = depth_r + 2'd1;
              level_left_nxt = body;
              if (body == 32'd0) begin
                fin = 1'b1;
              end
            end
          end else if (body != 32'd0) begin
            skip_left_nxt = body;
            phase_nxt     = PH_SKIP;
          end else if (bounded && (lvl_now == 32'd0)) begin
            fin = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (skip_left_r != 32'd0) begin
          skip_left_nxt = skip_left_r - 32'd1;
        end
        if (bounded && (level_left_r != 32'd0)) begin
          level_left_nxt = lvl_dec;
        end
        if (skip_left_nxt == 32'd0) begin
          phase_nxt = PH_HEADER;
          // Parent exhausted without a match.
          if (bounded && (level_left_nxt == 32'd0)) begin
            fin = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pl_left_r != 32'd0) begin
          pl_left_nxt = pl_left_r - 32'd1;
        end
        res_vld              = 1'b1;
        res.result_kind      = KIND_PAYLOAD;
        res.payload_byte     = item.data_byte;
        res.payload_size     = pl_total_r;
        res.payload_last     = (pl_left_nxt == 32'd0);
        if (pl_left_nxt == 32'd0) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    // A terminal result ends the search until the end of the file.
    if (fin) begin
      res_vld         = 1'b1;
      res             = '0;
      res.result_kind = fin_kind;
      phase_nxt       = PH_DONE;
    end

    // End of file: an unfinished search reports not found, then restarts.
    if (item.end_of_file) begin
      if (phase_nxt != PH_DONE) begin
        res_vld         = 1'b1;
        res             = '0;
        res.result_kind = KIND_NOT_FOUND;
      end
      phase_nxt      = PH_HEADER;
      hdr_shift_nxt  = '0;
      hdr_count_nxt  = 3'd0;
      skip_left_nxt  = '0;
      level_left_nxt = '1;
      depth_nxt      = 2'd0;
      pl_left_nxt    = '0;
      pl_total_nxt   = '0;
    end
  end

  // Search control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_count_r  <= 3'd0;
      skip_left_r  <= '0;
      level_left_r <= '1;
      depth_r      <= 2'd0;
      pl_left_r    <= '0;
    end else if (item_go) begin
      phase_r      <= phase_nxt;
      hdr_count_r  <= hdr_count_nxt;
      skip_left_r  <= skip_left_nxt;
      level_left_r <= level_left_nxt;
      depth_r      <= depth_nxt;
      pl_left_r    <= pl_left_nxt;
    end
  end

  // Header bytes and the size latch are payload and need no reset.
  always_ff @(posedge clk) begin
    if (item_go) begin
      hdr_shift_r <= hdr_shift_nxt;
      pl_total_r  <= pl_total_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mbpl_out_reg.sv
// Result register stage of the media box path locator.
// Depends on mbpl_pkg for the result request type.
`default_nettype none

module mbpl_out_reg
  import mbpl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    item_go,
  input  wire logic    res_vld,
  input  wire result_t res,
  output logic         out_free,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res
);

  logic    vld_r;
  result_t res_r;

  // The register may load when empty or when its request is taken now.
  assign out_free = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= item_go && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && item_go && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// File: bench/tb_media_box_path_locator_unit.sv
// Self-checking testbench for media_box_path_locator_unit: streams box-structured
// files under several search paths and checks each result against a built-in model.
// Depends on mbpl_pkg and the RTL of media_box_path_locator_unit.
`timescale 1ns / 100ps

module tb_media_box_path_locator_unit
  import mbpl_pkg::*;
;

  localparam int CLK_PERIOD      = 12;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int IDLE_PCT        = 27;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_BYTES    = 1900;
  localparam int PHASE_BYTES     = 200;

  typedef logic [7:0] bytes_t[$];

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [31:0] out_payload_size;
  logic        out_payload_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_PATH_LENGTH;
  logic [31:0] cfg_data = 32'h0;

  // Requests waiting to be sent, and results the model expects.
  in_item_t pending_items[$];
  result_t  expected_results[$];
  in_item_t send_item;

  // Bookkeeping shared between the processes.
  int sent_count = 0;
  int taken_count = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int fed_bytes = 0;
  int file_count = 0;
  int payload_seen = 0;
  int not_found_seen = 0;
  int malformed_seen = 0;
  int phase_no = 0;
  int random_goal = 0;
  int phase_goal = 0;
  bit quiet_mode = 1'b0;
  bit drain_pause = 1'b0;

  // Path currently programmed, as the stimulus sees it.
  logic [1:0]  plan_len = RST_PATH_LENGTH;
  logic [31:0] plan_types [3] = '{RST_TYPE_FIRST, RST_TYPE_SECOND, RST_TYPE_THIRD};

  // Model registers and search state.
  logic [1:0]  path_len_reg;
  logic [31:0] path_type_reg [TYPE_REGS];
  logic [63:0] hdr_shift;
  logic [3:0]  hdr_count;
  logic [31:0] skip_left;
  logic [31:0] level_left [PATH_DEPTH];
  logic [1:0]  depth_at;
  phase_t      search_phase;
  logic [31:0] body_left;
  logic [31:0] body_total;

  media_box_path_locator_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_payload_size (out_payload_size),
    .out_payload_last (out_payload_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Search model
  // ---------------------------------------------------------------------------

  function automatic void restart_search();
    hdr_shift = '0;
    hdr_count = '0;
    skip_left = '0;
    for (int i = 0; i < PATH_DEPTH; i++) level_left[i] = '1;
    depth_at = '0;
    search_phase = PH_HEADER;
    body_left = '0;
    body_total = '0;
  endfunction

  function automatic void locator_reset();
    path_len_reg = RST_PATH_LENGTH;
    path_type_reg[0] = RST_TYPE_FIRST;
    path_type_reg[1] = RST_TYPE_SECOND;
    path_type_reg[2] = RST_TYPE_THIRD;
    restart_search();
  endfunction

  function automatic void locator_config(input logic [1:0] index, input logic [31:0] value);
    case (index)
      CFG_PATH_LENGTH: path_len_reg = value[1:0];
      CFG_TYPE_FIRST:  path_type_reg[0] = value;
      CFG_TYPE_SECOND: path_type_reg[1] = value;
      CFG_TYPE_THIRD:  path_type_reg[2] = value;
      default: ;
    endcase
  endfunction

  // A length of zero searches one level; anything deeper than supported is capped.
  function automatic logic [1:0] active_length();
    logic [1:0] n;
    n = path_len_reg;
    if (n == 2'd0) n = 2'd1;
    if (n > LEN_MAX) n = LEN_MAX;
    return n;
  endfunction

  // A terminal result stops the search until the end of the file.
  function automatic result_t conclude(input logic [1:0] kind);
    result_t res;
    res = '0;
    res.result_kind = kind;
    search_phase = PH_DONE;
    return res;
  endfunction

  // Advances the model by one byte and queues the result it causes, if any.
  task automatic locate_step(input logic [7:0] b, input logic eof);
    logic [1:0]  d;
    logic        bounded;
    logic [31:0] box_len;
    logic [31:0] box_type;
    logic [31:0] body;
    logic [1:0]  len;
    result_t     res;
    bit          hit;
    d = depth_at;
    bounded = (d != 2'd0);
    res = '0;
    hit = 1'b0;
    if (d >= PATH_DEPTH) begin
      d = '0;
      depth_at = '0;
      bounded = 1'b0;
    end
    case (search_phase)
      PH_HEADER: begin
        if (bounded) level_left[d] = level_left[d] - 1;
        hdr_shift = {hdr_shift[55:0], b};
        hdr_count = hdr_count + 1;
        if (hdr_count < HDR_BYTES) begin
          // The parent box ran out part way through a child header.
          if (bounded && level_left[d] == 0) begin
            res = conclude(KIND_MALFORMED);
            hit = 1'b1;
          end
        end else begin
          box_len = hdr_shift[63:32];
          box_type = hdr_shift[31:0];
          len = active_length();
          hdr_count = '0;
          if (box_len < HDR_BYTES) begin
            res = conclude(KIND_MALFORMED);
            hit = 1'b1;
          end else begin
            body = box_len - HDR_BYTES;
            if (bounded && body > level_left[d]) begin
              res = conclude(KIND_MALFORMED);
              hit = 1'b1;
            end else if (d < len && box_type == path_type_reg[d]) begin
              if (d + 1 >= len) begin
                if (body == 0) begin
                  res = conclude(KIND_NOT_FOUND);
                  hit = 1'b1;
                end else begin
                  body_left = body;
                  body_total = body;
                  search_phase = PH_PAYLOAD;
                end
              end else begin
                // Descend: the child search is bounded by this box's body.
                depth_at = d + 2'd1;
                level_left[d + 1] = body;
                if (body == 0) begin
                  res = conclude(KIND_NOT_FOUND);
                  hit = 1'b1;
                end
              end
            end else if (body > 0) begin
              skip_left = body;
              search_phase = PH_SKIP;
            end else if (bounded && level_left[d] == 0) begin
              res = conclude(KIND_NOT_FOUND);
              hit = 1'b1;
            end
          end
        end
      end
      PH_SKIP: begin
        if (skip_left > 0) skip_left = skip_left - 1;
        if (bounded && level_left[d] > 0) level_left[d] = level_left[d] - 1;
        if (skip_left == 0) begin
          search_phase = PH_HEADER;
          if (bounded && level_left[d] == 0) begin
            res = conclude(KIND_NOT_FOUND);
            hit = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (body_left > 0) body_left = body_left - 1;
        res.result_kind = KIND_PAYLOAD;
        res.payload_byte = b;
        res.payload_size = body_total;
        res.payload_last = (body_left == 0);
        hit = 1'b1;
        if (body_left == 0) search_phase = PH_DONE;
      end
      default: ;
    endcase
    // The end of the file closes any search still open and starts a new one.
    if (eof) begin
      if (search_phase != PH_DONE) begin
        res = conclude(KIND_NOT_FOUND);
        hit = 1'b1;
      end
      restart_search();
    end
    if (hit) expected_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: model update on input requests, result check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      locator_reset();
    end else begin
      if (cfg_valid && cfg_ready) locator_config(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        taken_count++;
        locate_step(in_data_byte, in_end_of_file);
      end
      if (out_valid && !out_stall) begin
        case (out_result_kind)
          KIND_PAYLOAD:   payload_seen++;
          KIND_NOT_FOUND: not_found_seen++;
          default:        malformed_seen++;
        endcase
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte 0x%0h",
                   $time, out_result_kind, out_payload_byte);
          $display("  size 0x%0h last %0b", out_payload_size, out_payload_last);
          error_count++;
        end else begin
          check_field("result_kind", expected_results[0].result_kind, out_result_kind);
          check_field("payload_byte", expected_results[0].payload_byte, out_payload_byte);
          check_field("payload_size", expected_results[0].payload_size, out_payload_size);
          check_field("payload_last", expected_results[0].payload_last, out_payload_last);
          void'(expected_results.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: a request stays on the port until taken, then the next one may follow.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!(in_valid && sent_count != taken_count)) begin
      if (rst_n && !drain_pause && pending_items.size() != 0 &&
          (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
        send_item = pending_items.pop_front();
        in_data_byte <= send_item.data_byte;
        in_end_of_file <= send_item.end_of_file;
        in_valid <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // File construction
  // ---------------------------------------------------------------------------

  function automatic void append(ref bytes_t dst, input bytes_t src);
    foreach (src[i]) dst.push_back(src[i]);
  endfunction

  function automatic bytes_t header_bytes(input logic [31:0] box_len,
                                          input logic [31:0] box_type);
    bytes_t hdr;
    for (int i = 3; i >= 0; i--) hdr.push_back(box_len[8*i +: 8]);
    for (int i = 3; i >= 0; i--) hdr.push_back(box_type[8*i +: 8]);
    return hdr;
  endfunction

  function automatic logic [31:0] four_cc();
    return {8'($urandom_range(97, 122)), 8'($urandom_range(97, 122)),
            8'($urandom_range(97, 122)), 8'($urandom_range(97, 122))};
  endfunction

  function automatic logic [31:0] random_type();
    int roll;
    roll = $urandom_range(7);
    if (roll == 0) return 32'h0;
    if (roll == 1) return 32'hFFFF_FFFF;
    return four_cc();
  endfunction

  function automatic int plan_depth();
    return (plan_len == 2'd0) ? 1 : int'(plan_len);
  endfunction

  // A box that the search should pass over; now and then it carries a path type
  // belonging to another level.
  function automatic bytes_t decoy_box(input int level);
    bytes_t box;
    bytes_t body;
    logic [31:0] box_type;
    box_type = ($urandom_range(3) == 0) ? plan_types[$urandom_range(2)] : four_cc();
    if (level < plan_depth() && box_type == plan_types[level]) box_type[0] = ~box_type[0];
    repeat ($urandom_range(6)) body.push_back(8'($urandom));
    box = header_bytes(32'(HDR_BYTES + body.size()), box_type);
    append(box, body);
    return box;
  endfunction

  // A box on the search path, with its children or payload. Occasionally it is
  // empty, lacks its child, or carries a size that disagrees with its contents.
  function automatic bytes_t path_box(input int level);
    bytes_t box;
    bytes_t body;
    logic [31:0] box_len;
    int roll;
    roll = $urandom_range(99);
    if (level + 1 < plan_depth()) begin
      if (roll >= 6) begin
        repeat ($urandom_range(2)) append(body, decoy_box(level + 1));
        if (roll >= 14) append(body, path_box(level + 1));
        repeat ($urandom_range(1)) append(body, decoy_box(level + 1));
      end
    end else if (roll >= 6) begin
      repeat ((roll < 12) ? $urandom_range(20, 48) : $urandom_range(1, 10))
        body.push_back(8'($urandom));
    end
    box_len = 32'(HDR_BYTES + body.size());
    roll = $urandom_range(99);
    if (roll < 3) begin
      box_len = $urandom_range(7);
    end else if (roll < 11) begin
      if (roll[0]) box_len = box_len + $urandom_range(1, 10);
      else box_len = box_len - $urandom_range(1, 10);
    end
    box = header_bytes(box_len, plan_types[level]);
    append(box, body);
    return box;
  endfunction

  // Mostly well-formed files; the rest are damaged, cut short, or plain noise.
  function automatic bytes_t random_file();
    bytes_t f;
    int roll;
    int cut;
    roll = $urandom_range(99);
    if (roll < 85) begin
      repeat ($urandom_range(2)) append(f, decoy_box(0));
      append(f, path_box(0));
      repeat ($urandom_range(1)) append(f, decoy_box(0));
      if (roll >= 75) begin
        cut = $urandom_range(f.size() - 1);
        if (roll < 80) f[cut] = f[cut] ^ (8'd1 << $urandom_range(7));
        else while (f.size() > cut + 1) void'(f.pop_back());
      end
    end else if (roll < 95) begin
      repeat ($urandom_range(1, 24)) f.push_back(8'($urandom));
    end else begin
      f = header_bytes($urandom, $urandom);
      repeat ($urandom_range(8)) f.push_back(8'($urandom));
    end
    return f;
  endfunction

  // Queues one file as requests, with end_of_file on its final byte.
  function automatic void push_file(input bytes_t f);
    in_item_t req;
    foreach (f[i]) begin
      req.data_byte = f[i];
      req.end_of_file = (i == f.size() - 1);
      pending_items.push_back(req);
    end
    fed_bytes += f.size();
    file_count++;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_path(input logic [1:0] len, input logic [31:0] t0,
                            input logic [31:0] t1, input logic [31:0] t2);
    plan_len = len;
    plan_types[0] = t0;
    plan_types[1] = t1;
    plan_types[2] = t2;
    // Upper data bits are junk for the length register and must be ignored.
    write_register(CFG_PATH_LENGTH, {30'($urandom), len});
    write_register(CFG_TYPE_FIRST, t0);
    write_register(CFG_TYPE_SECOND, t1);
    write_register(CFG_TYPE_THIRD, t2);
  endtask

  // Waits until every request is sent and every result has come back, then lets
  // any byte still inside the block run through.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bytes_t file_bytes;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: undersized box with extreme bytes, then a file of one byte.
    file_bytes = header_bytes(32'h0, 32'hFFFF_FFFF);
    file_bytes.push_back(8'hFF);
    push_file(file_bytes);
    file_bytes = {};
    file_bytes.push_back(8'h5A);
    push_file(file_bytes);
    wait_idle();

    // Directed: one-level path whose last payload byte ends the file.
    apply_path(2'd1, 32'h0, 32'hFFFF_FFFF, 32'h0);
    file_bytes = header_bytes(32'd10, 32'h0);
    file_bytes.push_back(8'hA5);
    file_bytes.push_back(8'h5A);
    push_file(file_bytes);

    // Random files, one path setting per phase.
    random_goal = fed_bytes + RANDOM_BYTES;
    while (fed_bytes < random_goal) begin
      wait_idle();
      case (phase_no)
        0: apply_path(RST_PATH_LENGTH, RST_TYPE_FIRST, RST_TYPE_SECOND, RST_TYPE_THIRD);
        1: apply_path(2'd0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        2: apply_path(2'd2, 32'h0, 32'hFFFF_FFFF, four_cc());
        3: apply_path(2'd3, four_cc(), four_cc(), four_cc());
        default: apply_path(2'($urandom_range(3)), random_type(), random_type(),
                            random_type());
      endcase
      quiet_mode = (phase_no == 3);
      // Hold the output back while requests keep arriving, so the block backs up.
      if (phase_no == 1) hold_requests++;
      phase_goal = fed_bytes + PHASE_BYTES;
      while (fed_bytes < phase_goal) push_file(random_file());
      // Part way through, stop sending until every result is in.
      if (phase_no == 4) begin
        while (pending_items.size() > PHASE_BYTES / 2) @(posedge clk);
        drain_pause = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        drain_pause = 1'b0;
      end
      phase_no++;
    end
    wait_idle();

    $display("Checked %0d results: %0d payload bytes, %0d not found, %0d malformed.",
             payload_seen + not_found_seen + malformed_seen, payload_seen,
             not_found_seen, malformed_seen);
    $display("Fed %0d bytes in %0d files over %0d path settings.",
             fed_bytes, file_count, phase_no + 1);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
